### rtl/positional_array_list_assert.svh
// assertion macros used by the checker file pal_checker.sv
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// condition in the same cycle
`define PAL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pal assertion failed");

// condition in the following cycle
`define PAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pal assertion failed");

`endif

### rtl/pal_pkg.sv
package pal_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;
  localparam int CNT_OUT_W = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // width wide enough for positions, cell indexes and the count
  localparam int PW       = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LOCATE = 2'd2
  } pal_kind_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } pal_in_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] removed_value;
    logic [POS_W-1:0]         found_index;
    logic [CNT_OUT_W-1:0]     count;
  } pal_out_t;

  // broadcast to every cell
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic [PW-1:0]            pos;
    logic [PW-1:0]            cnt;
    logic signed [DATA_W-1:0] value;
  } pal_ctl_t;

endpackage

### rtl/pal_cell.sv
module pal_cell
  import pal_pkg::*;
(
  input  logic                     clk,
  input  logic [PW-1:0]            idx,
  input  pal_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] prev_data,
  input  logic signed [DATA_W-1:0] next_data,
  output logic signed [DATA_W-1:0] data,
  output logic                     match,
  output logic signed [DATA_W-1:0] hit_data
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins && (idx > ctl.pos)) begin
      data_nxt = prev_data;
    end else if (ctl.ins && (idx == ctl.pos)) begin
      data_nxt = ctl.value;
    end else if (ctl.del && (idx >= ctl.pos)) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  assign match    = (idx < ctl.cnt) && (data_r == ctl.value);
  // only the addressed cell drives its word, the rest give zero
  assign hit_data = (idx == ctl.pos) ? data_r : '0;

endmodule

### rtl/positional_array_list.sv
// a result strobes on out_valid in the cycle after start is taken
// throughput: one request per cycle, busy stays low; the cell row shifts
// and compares all entries in the same cycle, then the result register loads
// reset: synchronous active-low rst_n clears the count and out_valid;
// entry contents are not cleared, only entries below the count are read
// the receiver cannot stall; each result is shown for exactly one cycle
module positional_array_list
  import pal_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pal_in_t  in_data,
  output logic     out_valid,
  output pal_out_t out_data
);

  logic                     take;
  logic                     ins_ok;
  logic                     del_ok;
  logic                     loc;
  logic [PW-1:0]            pos_w;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [PW-1:0]            cnt_w;
  pal_ctl_t                 ctl;
  logic                     out_valid_r;
  pal_out_t                 out_data_r;
  pal_out_t                 out_nxt;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_hit  [CAPACITY];
  logic [CAPACITY-1:0]      cell_match;
  logic signed [DATA_W-1:0] removed;
  logic                     found;
  logic [PW-1:0]            found_idx;

  assign take   = start;
  assign busy   = 1'b0;
  assign pos_w  = PW'(in_data.position);
  assign cnt_w  = PW'(cnt_r);
  assign ins_ok = take && (in_data.kind == KIND_INSERT) &&
                  (cnt_w < PW'(CAPACITY)) && (pos_w <= cnt_w);
  assign del_ok = take && (in_data.kind == KIND_DELETE) && (pos_w < cnt_w);
  assign loc    = in_data.kind == KIND_LOCATE;

  always_comb begin
    ctl       = '0;
    ctl.ins   = ins_ok;
    ctl.del   = del_ok;
    ctl.pos   = pos_w;
    ctl.cnt   = cnt_w;
    ctl.value = in_data.value;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [DATA_W-1:0] prev_d;
      logic signed [DATA_W-1:0] next_d;
      if (g == 0) begin : g_first
        assign prev_d = '0;
      end else begin : g_mid_lo
        assign prev_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign next_d = cell_data[g];
      end else begin : g_mid_hi
        assign next_d = cell_data[g+1];
      end
      pal_cell u_cell (
        .clk       (clk),
        .idx       (PW'(g)),
        .ctl       (ctl),
        .prev_data (prev_d),
        .next_data (next_d),
        .data      (cell_data[g]),
        .match     (cell_match[g]),
        .hit_data  (cell_hit[g])
      );
    end
  endgenerate

  // lowest matching cell wins
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        found     = 1'b1;
        found_idx = PW'(i);
      end
    end
  end

  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed = removed | cell_hit[i];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ins_ok) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (del_ok) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_nxt               = '0;
    out_nxt.ok            = ins_ok || del_ok || (loc && found);
    out_nxt.removed_value = del_ok ? removed : '0;
    out_nxt.found_index   = (loc && found) ? POS_W'(found_idx) : '0;
    out_nxt.count         = CNT_OUT_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/pal_checker.sv
`include "positional_array_list_assert.svh"

module pal_checker
  import pal_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input pal_in_t  in_data,
  input logic     out_valid,
  input pal_out_t out_data
);

  `PAL_ASSERT_NEXT(a_result_follows, start && !busy, out_valid)
  `PAL_ASSERT_NEXT(a_no_stray_result, !(start && !busy), !out_valid)
  `PAL_ASSERT_SAME(a_fail_zero, out_valid && !out_data.ok, out_data.removed_value == '0 && out_data.found_index == '0)
  `PAL_ASSERT_NEXT(a_locate_keeps_removed_zero, start && !busy && in_data.kind == KIND_LOCATE, out_data.removed_value == '0)

endmodule

bind positional_array_list pal_checker u_pal_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

### bench/positional_array_list_checker.sv
module positional_array_list_checker
  import pal_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  pal_in_t  in_data,
  input  logic     out_valid,
  input  pal_out_t out_data,
  input  logic     sweep,
  output int       pending,
  output int       fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 40;

  logic signed [DATA_W-1:0] list_words [CAPACITY];
  int                       list_len;
  pal_out_t                 expected_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    list_len   = 0;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    fail_count++;
    if (fail_count <= MAX_PRINTED)
      $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
  endtask

  // shadow list update, returns the result the block should give
  function automatic pal_out_t apply_request(pal_in_t req);
    pal_out_t res;
    int       p;
    int       i;
    logic     hit;
    res = '0;
    p   = int'(req.position);
    hit = 1'b0;
    case (req.kind)
      KIND_INSERT: begin
        if (list_len < CAPACITY && p <= list_len) begin
          for (i = list_len; i > p; i--)
            list_words[i] = list_words[i-1];
          list_words[p] = req.value;
          list_len++;
          res.ok = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (p < list_len) begin
          res.removed_value = list_words[p];
          for (i = p; i + 1 < list_len; i++)
            list_words[i] = list_words[i+1];
          list_len--;
          res.ok = 1'b1;
        end
      end
      KIND_LOCATE: begin
        for (i = 0; i < list_len && !hit; i++) begin
          if (list_words[i] == req.value) begin
            hit             = 1'b1;
            res.ok          = 1'b1;
            res.found_index = i[POS_W-1:0];
          end
        end
      end
      default: ;
    endcase
    res.count = list_len[CNT_OUT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    pal_out_t want;
    if (!rst_n) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report("result with nothing outstanding", 64'(out_data), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.ok !== want.ok)
            report("ok", 64'(out_data.ok), 64'(want.ok));
          if (out_data.removed_value !== want.removed_value)
            report("removed_value", 64'(unsigned'(out_data.removed_value)),
                   64'(unsigned'(want.removed_value)));
          if (out_data.found_index !== want.found_index)
            report("found_index", 64'(out_data.found_index), 64'(want.found_index));
          if (out_data.count !== want.count)
            report("count", 64'(out_data.count), 64'(want.count));
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_request(in_data));
      if (sweep) begin
        while (expected_results.size() > 0) begin
          want = expected_results.pop_front();
          report("result never came", '0, 64'(want));
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

### bench/positional_array_list_tb.sv
module positional_array_list_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pal_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 750;
  localparam int TAIL_ITEMS   = 100;
  localparam int PHASE_ITEMS  = 60;
  localparam int DRAIN_LIMIT  = 200;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  pal_in_t  in_data;
  logic     out_valid;
  pal_out_t out_data;
  logic     sweep;
  int       pending;
  int       fail_count;
  int       sent_by_kind [4];
  int       phases;

  positional_array_list uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  positional_array_list_checker list_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .sweep     (sweep),
    .pending   (pending),
    .fail_count(fail_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #(2_000_000);
    $display("FAIL positional_array_list");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_request(input logic [1:0] kind, input logic [POS_W-1:0] position,
                              input logic signed [DATA_W-1:0] value);
    pal_in_t req;
    req.kind     = kind;
    req.position = position;
    req.value    = value;
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    sent_by_kind[kind]++;
    @(negedge clk);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 7)) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4)
      return $urandom_range(0, 7) - 4;   // small pool so locates hit and duplicates occur
    if (r == 4) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int          n;
    int          r;
    int          waited;
    int          gap_odds;
    logic        filling;
    logic [1:0]  kind;
    logic [POS_W-1:0] pos;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    sweep   = 1'b0;
    phases  = 0;
    foreach (sent_by_kind[k]) sent_by_kind[k] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list corner cases
    send_request(KIND_DELETE, 4'd0, 32'sd0);
    send_request(KIND_LOCATE, 4'd0, 32'sd0);
    send_request(KIND_INSERT, 4'd1, 32'sd5);
    send_request(KIND_UNUSED, 4'd15, -32'sd1);
    // front, end and middle inserts with extreme values
    send_request(KIND_INSERT, 4'd0, 32'sh8000_0000);
    send_request(KIND_INSERT, 4'd0, 32'sh7fff_ffff);
    send_request(KIND_INSERT, 4'd2, -32'sd1);
    idle_burst();
    send_request(KIND_INSERT, 4'd1, 32'sd0);
    for (n = 4; n < CAPACITY; n++)
      send_request(KIND_INSERT, n[POS_W-1:0], 32'sd100 + n);
    // full list
    send_request(KIND_INSERT, 4'd3, 32'sd1);
    send_request(KIND_LOCATE, 4'd0, 32'sd115);
    send_request(KIND_LOCATE, 4'd0, 32'sd12345);
    send_request(KIND_DELETE, 4'd15, 32'sd0);
    send_request(KIND_DELETE, 4'd0, 32'sd0);
    send_request(KIND_DELETE, 4'd15, 32'sd0);

    filling  = 1'b1;
    gap_odds = 4;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n % PHASE_ITEMS == 0) begin
        filling = ~filling;
        phases++;
        // gap odds of zero give a stretch with no idling
        gap_odds = $urandom_range(0, 2) * 4;
      end
      r = $urandom_range(0, 99);
      if (filling)
        kind = (r < 55) ? KIND_INSERT : (r < 70) ? KIND_DELETE :
               (r < 96) ? KIND_LOCATE : KIND_UNUSED;
      else
        kind = (r < 20) ? KIND_INSERT : (r < 65) ? KIND_DELETE :
               (r < 96) ? KIND_LOCATE : KIND_UNUSED;
      pos = POS_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15));
      if (gap_odds != 0 && n < RANDOM_ITEMS - TAIL_ITEMS && $urandom_range(1, gap_odds) == 1)
        idle_burst();
      send_request(kind, pos, pick_value());
      if (kind != KIND_UNUSED)
        n++;
    end
    start <= 1'b0;

    for (waited = 0; pending != 0 && waited < DRAIN_LIMIT; waited++)
      @(negedge clk);
    repeat (4) @(negedge clk);
    sweep <= 1'b1;
    @(negedge clk);
    sweep <= 1'b0;
    @(negedge clk);

    $display("requests sent: %0d insert, %0d delete, %0d locate, %0d unused kind",
             sent_by_kind[KIND_INSERT], sent_by_kind[KIND_DELETE],
             sent_by_kind[KIND_LOCATE], sent_by_kind[KIND_UNUSED]);
    $display("%0d alternating fill and drain phases with random request gaps", phases);
    if (fail_count == 0)
      $display("PASS positional_array_list");
    else
      $display("FAIL positional_array_list");
    $finish;
  end

endmodule
